@@ rtl/lgge_pkg.sv @@
package lgge_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_TOGGLE  = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_READ    = 2'd3
   } lgge_kind_type;

   typedef struct packed {
      lgge_kind_type kind;
      logic [5:0]    row;
      logic [5:0]    col;
      logic          value;
   } lgge_req_type;

   typedef struct packed {
      logic cell_value;
      logic done_res;
   } lgge_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL_MOD,
      ST_ADV_PRIME,
      ST_ADV_ROW,
      ST_RESULT
   } lgge_state_type;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // live neighbors of one cell: three above, left and right, three below
   function automatic logic [3:0] neighbor_count(input logic [2:0] above3,
                                                 input logic       left_cell,
                                                 input logic       right_cell,
                                                 input logic [2:0] below3);
      return 4'(above3[0]) + 4'(above3[1]) + 4'(above3[2]) +
             4'(left_cell) + 4'(right_cell) +
             4'(below3[0]) + 4'(below3[1]) + 4'(below3[2]);
   endfunction

   // b3/s23 rule
   function automatic logic next_cell(input logic self_alive, input logic [3:0] count);
      return (count == BIRTH_COUNT) || (self_alive && (count == SURVIVE_COUNT));
   endfunction

endpackage

@@ rtl/lgge_row_mem.sv @@
module lgge_row_mem
   import lgge_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] row_store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lgge_row_rule.sv @@
module lgge_row_rule
   import lgge_pkg::*;
#(
   parameter int GRID_WIDTH = 64
) (
   input  logic [GRID_WIDTH-1:0] above_row,
   input  logic [GRID_WIDTH-1:0] cur_row,
   input  logic [GRID_WIDTH-1:0] below_row,
   output logic [GRID_WIDTH-1:0] next_row
);

   // one dead cell padded at each edge, cell c sits at position c+1
   logic [GRID_WIDTH+1:0] above_ext;
   logic [GRID_WIDTH+1:0] cur_ext;
   logic [GRID_WIDTH+1:0] below_ext;

   assign above_ext = {1'b0, above_row, 1'b0};
   assign cur_ext   = {1'b0, cur_row, 1'b0};
   assign below_ext = {1'b0, below_row, 1'b0};

   always_comb begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
         next_row[c] = next_cell(cur_row[c],
                                 neighbor_count(above_ext[c +: 3], cur_ext[c],
                                                cur_ext[c+2], below_ext[c +: 3]));
      end
   end

endmodule

@@ rtl/life_grid_generation_engine_unit.sv @@
// cell write, toggle or read: the row is fetched on transfer in; ST_CELL_MOD writes it
// back for a write or toggle and registers the result, off the grid ST_IDLE registers it
// advance: after ST_ADV_PRIME, one whole row per cycle through the row memory port
// a new item is taken only in ST_IDLE, after the previous result is loaded for output;
// this waits longer while rsp_stall holds the result; reset: synchronous, then a clearing
// pass zeroes the grid; no item is taken until it ends
module life_grid_generation_engine_unit
   import lgge_pkg::*;
#(
   parameter int GRID_HEIGHT = 64,
   parameter int GRID_WIDTH  = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lgge_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lgge_rsp_type rsp_data
);

   localparam int RW = $clog2(GRID_HEIGHT);
   localparam int CW = $clog2(GRID_WIDTH);
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

   // control
   lgge_state_type state_ff, state_in;
   logic [RW-1:0]  row_cnt_ff, row_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [RW-1:0]         cell_row_ff, cell_row_in;
   logic [CW-1:0]         cell_col_ff, cell_col_in;
   lgge_kind_type         cell_kind_ff, cell_kind_in;
   logic                  cell_val_ff, cell_val_in;
   logic [GRID_WIDTH-1:0] above_ff, above_in;
   logic [GRID_WIDTH-1:0] cur_ff, cur_in;
   lgge_rsp_type          res_ff, res_in;
   lgge_rsp_type          rsp_data_ff, rsp_data_in;

   // memory port
   logic                  mem_wr_en;
   logic [RW-1:0]         mem_wr_addr;
   logic [GRID_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [RW-1:0]         mem_rd_addr;
   logic [GRID_WIDTH-1:0] mem_rd_data;

   logic                  req_fire;
   logic                  rsp_load;
   logic                  in_grid;
   logic                  last_row;
   logic [GRID_WIDTH-1:0] below_row;
   logic [GRID_WIDTH-1:0] next_row;
   logic                  old_bit;
   logic                  new_bit;
   logic [GRID_WIDTH-1:0] mod_word;

   // whole grid, one row per entry
   lgge_row_mem #(
      .DEPTH (GRID_HEIGHT),
      .WIDTH (GRID_WIDTH)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // new generation of the row in the middle
   lgge_row_rule #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_row_rule (
      .above_row (above_ff),
      .cur_row   (cur_ff),
      .below_row (below_row),
      .next_row  (next_row)
   );

   assign req_fire = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   assign in_grid  = (int'(req_data.row) < GRID_HEIGHT) && (int'(req_data.col) < GRID_WIDTH);
   assign last_row = (row_cnt_ff == LAST_ROW);

   // rows below the grid are dead
   assign below_row = last_row ? '0 : mem_rd_data;

   // read-modify-write of one cell in the fetched row
   always_comb begin
      old_bit = mem_rd_data[cell_col_ff];
      case (cell_kind_ff)
         KIND_WRITE:  new_bit = cell_val_ff;
         KIND_TOGGLE: new_bit = !old_bit;
         default:     new_bit = old_bit;
      endcase
      mod_word              = mem_rd_data;
      mod_word[cell_col_ff] = new_bit;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_row) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_ADVANCE) state_in = ST_ADV_PRIME;
               else if (in_grid)                  state_in = ST_CELL_MOD;
               else                               state_in = ST_RESULT;
            end
         end
         ST_CELL_MOD:  state_in = ST_RESULT;
         ST_ADV_PRIME: state_in = ST_ADV_ROW;
         ST_ADV_ROW: begin
            if (last_row) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = row_cnt_ff;
      mem_wr_data  = next_row;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = row_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      cell_row_in  = cell_row_ff;
      cell_col_in  = cell_col_ff;
      cell_kind_in = cell_kind_ff;
      cell_val_in  = cell_val_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            row_cnt_in  = last_row ? '0 : row_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               cell_row_in  = RW'(req_data.row);
               cell_col_in  = CW'(req_data.col);
               cell_kind_in = req_data.kind;
               cell_val_in  = req_data.value;
               row_cnt_in   = '0;
               if (req_data.kind == KIND_ADVANCE) begin
                  // fetch row 0 first
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
               end else if (in_grid) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = RW'(req_data.row);
               end else begin
                  // outside the grid: nothing done, not done
                  res_in.cell_value = 1'b0;
                  res_in.done_res   = 1'b0;
               end
            end
         end
         ST_CELL_MOD: begin
            mem_wr_en         = cell_kind_ff inside {KIND_WRITE, KIND_TOGGLE};
            mem_wr_addr       = cell_row_ff;
            mem_wr_data       = mod_word;
            res_in.cell_value = new_bit;
            res_in.done_res   = 1'b1;
         end
         ST_ADV_PRIME: begin
            // row 0 arrives, nothing above it
            above_in    = '0;
            cur_in      = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = RW'(1);
         end
         ST_ADV_ROW: begin
            // old rows live in the buffers, so writing back never races the reads
            mem_wr_en   = 1'b1;
            mem_wr_addr = row_cnt_ff;
            mem_wr_data = next_row;
            above_in    = cur_ff;
            cur_in      = below_row;
            if (int'(row_cnt_ff) + 2 < GRID_HEIGHT) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = RW'(int'(row_cnt_ff) + 2);
            end
            row_cnt_in        = last_row ? '0 : row_cnt_ff + 1'b1;
            res_in.cell_value = 1'b0;
            res_in.done_res   = 1'b1;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_row_ff  <= cell_row_in;
      cell_col_ff  <= cell_col_in;
      cell_kind_ff <= cell_kind_in;
      cell_val_ff  <= cell_val_in;
      above_ff     <= above_in;
      cur_ff       <= cur_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
